>>> hw/rtl/lts_pkg.sv
package lts_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam int KEY_W       = 32;
   localparam int CLASS_W     = 2;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 5;
   localparam int COUNT_W     = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 144;

   localparam logic [OP_W-1:0] OP_ACCESS     = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_LRU = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_KEY = 2'd2;

   localparam logic [CLASS_W-1:0] CLASS_PREFETCHED = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_PLAIN      = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN    = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_RESERVED   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [CLASS_W-1:0] page_class;
      logic               hit_mark;
   } entry_type;

   // Per-cell move command: take the entry of the more recent neighbor,
   // or of the less recent neighbor.
   typedef struct packed {
      logic take_prev;
      logic take_next;
   } ctl_type;

endpackage

>>> hw/rtl/lts_cell.sv
module lts_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  lts_pkg::ctl_type            ctl,
   input  lts_pkg::entry_type          prev_entry,
   input  lts_pkg::entry_type          next_entry,
   input  logic [lts_pkg::KEY_W-1:0]   cmp_key,
   output lts_pkg::entry_type          entry,
   output logic                        match
);

   logic                          valid_ff, valid_in;
   logic [lts_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lts_pkg::CLASS_W-1:0]   class_ff, class_in;
   logic                          hit_mark_ff, hit_mark_in;

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      class_in    = class_ff;
      hit_mark_in = hit_mark_ff;
      if (ctl.take_prev) begin
         valid_in    = prev_entry.valid;
         key_in      = prev_entry.key;
         class_in    = prev_entry.page_class;
         hit_mark_in = prev_entry.hit_mark;
      end else if (ctl.take_next) begin
         valid_in    = next_entry.valid;
         key_in      = next_entry.key;
         class_in    = next_entry.page_class;
         hit_mark_in = next_entry.hit_mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      class_ff    <= class_in;
      hit_mark_ff <= hit_mark_in;
   end

   assign entry = '{valid: valid_ff, key: key_ff, page_class: class_ff, hit_mark: hit_mark_ff};
   assign match = valid_ff && (key_ff == cmp_key);

endmodule

>>> hw/rtl/lts_chain.sv
module lts_chain #(
   parameter int ENTRIES = lts_pkg::ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lts_pkg::ctl_type            ctl [ENTRIES],
   input  lts_pkg::entry_type          head_entry,
   input  logic [lts_pkg::KEY_W-1:0]   cmp_key,
   input  logic [ENTRIES-1:0]          sel,
   output logic [ENTRIES-1:0]          valid,
   output logic [ENTRIES-1:0]          match,
   output lts_pkg::entry_type          sel_entry
);

   // Cell 0 is the most recent entry; valid entries are always packed
   // at the low end of the chain, so a cell's place is its recency rank.
   lts_pkg::entry_type entry_w [ENTRIES];
   lts_pkg::entry_type prev_w  [ENTRIES];
   lts_pkg::entry_type next_w  [ENTRIES];

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign prev_w[g] = head_entry;
         end else begin : g_mid
            assign prev_w[g] = entry_w[g-1];
         end
         if (g == ENTRIES - 1) begin : g_tail
            assign next_w[g] = '0;
         end else begin : g_body
            assign next_w[g] = entry_w[g+1];
         end

         lts_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl[g]),
            .prev_entry (prev_w[g]),
            .next_entry (next_w[g]),
            .cmp_key    (cmp_key),
            .entry      (entry_w[g]),
            .match      (match[g])
         );

         assign valid[g] = entry_w[g].valid;
      end
   endgenerate

   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sel_entry = sel_entry | (entry_w[i] & {$bits(lts_pkg::entry_type){sel[i]}});
      end
   end

endmodule

>>> hw/rtl/lru_table_with_prefetch_stats_unit.sv
// A request is taken only while idle; its key compare result is registered, then the
// chain shift and the response are registered together. A new request is not taken
// until the response for the last one has been registered; a stalled response holds
// the shift step until it is taken.
// Reset clears the valid bits, the fill count, the hit and insert counters and
// the response valid; stored keys, classes and hit marks are not cleared.
module lru_table_with_prefetch_stats_unit #(
   parameter int ENTRIES = lts_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] key, [33:32] page_class, [39:34] zero
   input  logic [lts_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] op
   input  logic [lts_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] hit, [32:1] out_key, [34:33] out_class, [35] out_was_hit,
   // [37:36] status, [42:38] occupancy, [74:43] prefetched_hits,
   // [106:75] plain_hits, [138:107] prefetched_inserts, [143:139] zero
   output logic [lts_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int PAD_W  = lts_pkg::RSP_TDATA_W - 3 * lts_pkg::COUNT_W
                           - lts_pkg::OCC_W - lts_pkg::STATUS_W - lts_pkg::CLASS_W
                           - lts_pkg::KEY_W - 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [lts_pkg::OP_W-1:0]       op_ff, op_in;
   logic [lts_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [lts_pkg::CLASS_W-1:0]    class_ff, class_in;
   logic [ENTRIES-1:0]             match_ff, match_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic [lts_pkg::COUNT_W-1:0]    pf_hits_ff, pf_hits_in;
   logic [lts_pkg::COUNT_W-1:0]    plain_hits_ff, plain_hits_in;
   logic [lts_pkg::COUNT_W-1:0]    pf_ins_ff, pf_ins_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lts_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   lts_pkg::ctl_type               ctl [ENTRIES];
   lts_pkg::entry_type             head_entry;
   lts_pkg::entry_type             sel_entry;
   logic [ENTRIES-1:0]             valid;
   logic [ENTRIES-1:0]             match;
   logic [ENTRIES-1:0]             lru_sel;
   logic [ENTRIES-1:0]             sel;
   logic [ENTRIES-1:0]             from_sel;
   logic [ENTRIES-1:0]             upto_sel;
   logic                           found;
   logic                           full;
   logic                           fire;
   logic                           do_hit;
   logic                           do_ins;
   logic                           do_rm;
   logic                           req_fire;

   logic                           o_hit;
   logic [lts_pkg::KEY_W-1:0]      o_key;
   logic [lts_pkg::CLASS_W-1:0]    o_class;
   logic                           o_was_hit;
   logic [lts_pkg::STATUS_W-1:0]   o_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign fire       = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_tready);

   // The least recent entry is the last valid cell of the packed chain.
   assign lru_sel  = valid & ~{1'b0, valid[ENTRIES-1:1]};
   assign sel      = (op_ff == lts_pkg::OP_REMOVE_LRU) ? lru_sel : match_ff;
   assign found    = |sel;
   assign full     = valid[ENTRIES-1];
   // For a one-hot select, these mark the cells at or above, and at or
   // below, the selected cell.
   assign upto_sel = ~(sel - ENTRIES'(1));
   assign from_sel = (sel << 1) - ENTRIES'(1);

   assign do_hit = (op_ff == lts_pkg::OP_ACCESS) && found;
   assign do_ins = (op_ff == lts_pkg::OP_ACCESS) && !found && !full;
   assign do_rm  = ((op_ff == lts_pkg::OP_REMOVE_LRU) || (op_ff == lts_pkg::OP_REMOVE_KEY))
                   && found;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         ctl[i].take_prev = fire && (do_ins || (do_hit && from_sel[i]));
         ctl[i].take_next = fire && do_rm && upto_sel[i];
      end
   end

   always_comb begin
      if (do_hit) begin
         head_entry = '{valid: 1'b1, key: sel_entry.key, page_class: sel_entry.page_class,
                        hit_mark: 1'b1};
      end else begin
         head_entry = '{valid: 1'b1, key: key_ff, page_class: class_ff, hit_mark: 1'b0};
      end
   end

   lts_chain #(
      .ENTRIES (ENTRIES)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .head_entry (head_entry),
      .cmp_key    (key_ff),
      .sel        (sel),
      .valid      (valid),
      .match      (match),
      .sel_entry  (sel_entry)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      class_in      = class_ff;
      match_in      = match_ff;
      fill_in       = fill_ff;
      pf_hits_in    = pf_hits_ff;
      plain_hits_in = plain_hits_ff;
      pf_ins_in     = pf_ins_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      o_hit         = 1'b0;
      o_key         = '0;
      o_class       = '0;
      o_was_hit     = 1'b0;
      o_status      = lts_pkg::STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_tuser;
               key_in = req_tdata[lts_pkg::KEY_W-1:0];
               class_in = req_tdata[lts_pkg::KEY_W +: lts_pkg::CLASS_W];
               // Class code three is stored as unknown.
               if (class_in == lts_pkg::CLASS_RESERVED) begin
                  class_in = lts_pkg::CLASS_UNKNOWN;
               end
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            match_in = match;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (fire) begin
               if (op_ff == lts_pkg::OP_ACCESS) begin
                  o_key = key_ff;
                  if (do_hit) begin
                     o_hit = 1'b1;
                     if (sel_entry.page_class == lts_pkg::CLASS_PREFETCHED) begin
                        pf_hits_in = pf_hits_ff + 1'b1;
                     end else if (sel_entry.page_class == lts_pkg::CLASS_PLAIN) begin
                        plain_hits_in = plain_hits_ff + 1'b1;
                     end
                  end else if (full) begin
                     o_status = lts_pkg::STATUS_FULL;
                  end else begin
                     fill_in = fill_ff + 1'b1;
                     if (class_ff == lts_pkg::CLASS_PREFETCHED) begin
                        pf_ins_in = pf_ins_ff + 1'b1;
                     end
                  end
               end else if ((op_ff == lts_pkg::OP_REMOVE_LRU) ||
                            (op_ff == lts_pkg::OP_REMOVE_KEY)) begin
                  if (op_ff == lts_pkg::OP_REMOVE_KEY) begin
                     o_key = key_ff;
                  end
                  if (found) begin
                     o_key     = sel_entry.key;
                     o_class   = sel_entry.page_class;
                     o_was_hit = sel_entry.hit_mark;
                     fill_in   = fill_ff - 1'b1;
                  end else begin
                     o_status = lts_pkg::STATUS_ABSENT;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, pf_ins_in, plain_hits_in, pf_hits_in,
                               lts_pkg::OCC_W'(fill_in), o_status, o_was_hit, o_class,
                               o_key, o_hit};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         pf_hits_ff    <= '0;
         plain_hits_ff <= '0;
         pf_ins_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pf_hits_ff    <= pf_hits_in;
         plain_hits_ff <= plain_hits_in;
         pf_ins_ff     <= pf_ins_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      class_ff    <= class_in;
      match_ff    <= match_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> bench/tb_top.sv
module tb_top;

   localparam int TBL_DEPTH = lts_pkg::ENTRIES_DEFAULT;
   localparam int POOL_SIZE = 24;
   localparam logic [lts_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

   typedef struct {
      logic                         hit;
      logic [lts_pkg::KEY_W-1:0]    out_key;
      logic [lts_pkg::CLASS_W-1:0]  out_class;
      logic                         out_was_hit;
      logic [lts_pkg::STATUS_W-1:0] status;
      logic [lts_pkg::OCC_W-1:0]    occupancy;
      logic [lts_pkg::COUNT_W-1:0]  prefetched_hits;
      logic [lts_pkg::COUNT_W-1:0]  plain_hits;
      logic [lts_pkg::COUNT_W-1:0]  prefetched_inserts;
   } table_rsp_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [lts_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [lts_pkg::OP_W-1:0]        req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [lts_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the table, updated in request order.
   logic [lts_pkg::KEY_W-1:0]   tbl_key       [TBL_DEPTH];
   logic                        tbl_valid     [TBL_DEPTH];
   logic [lts_pkg::CLASS_W-1:0] tbl_class     [TBL_DEPTH];
   logic                        tbl_hit_mark  [TBL_DEPTH];
   int                          tbl_rank      [TBL_DEPTH];
   int                          tbl_fill;
   logic [lts_pkg::COUNT_W-1:0] cnt_pf_hits;
   logic [lts_pkg::COUNT_W-1:0] cnt_plain_hits;
   logic [lts_pkg::COUNT_W-1:0] cnt_pf_inserts;

   table_rsp_type               expected_table_rsp[$];
   logic [lts_pkg::KEY_W-1:0]   key_pool[POOL_SIZE];
   int                          error_count = 0;
   bit                          idle_on = 1'b1;
   int                          hold_cycles = 0;

   lru_table_with_prefetch_stats_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int find_entry(logic [lts_pkg::KEY_W-1:0] k);
      for (int i = 0; i < TBL_DEPTH; i++)
         if (tbl_valid[i] && tbl_key[i] == k)
            return i;
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the response it must produce.
   function automatic table_rsp_type apply_table_op(logic [lts_pkg::OP_W-1:0] op,
                                                    logic [lts_pkg::KEY_W-1:0] k,
                                                    logic [lts_pkg::CLASS_W-1:0] cls);
      table_rsp_type r;
      int            s;
      int            rank;
      r.hit         = 1'b0;
      r.out_key     = '0;
      r.out_class   = '0;
      r.out_was_hit = 1'b0;
      r.status      = lts_pkg::STATUS_OK;
      if (cls == lts_pkg::CLASS_RESERVED)
         cls = lts_pkg::CLASS_UNKNOWN;
      case (op)
         lts_pkg::OP_ACCESS: begin
            r.out_key = k;
            s = find_entry(k);
            if (s >= 0) begin
               r.hit = 1'b1;
               tbl_hit_mark[s] = 1'b1;
               if (tbl_class[s] == lts_pkg::CLASS_PREFETCHED)
                  cnt_pf_hits++;
               else if (tbl_class[s] == lts_pkg::CLASS_PLAIN)
                  cnt_plain_hits++;
               rank = tbl_rank[s];
               for (int i = 0; i < TBL_DEPTH; i++)
                  if (tbl_valid[i] && i != s && tbl_rank[i] < rank)
                     tbl_rank[i]++;
               tbl_rank[s] = 0;
            end else if (tbl_fill >= TBL_DEPTH) begin
               r.status = lts_pkg::STATUS_FULL;
            end else begin
               s = -1;
               for (int i = TBL_DEPTH - 1; i >= 0; i--)
                  if (!tbl_valid[i])
                     s = i;
               for (int i = 0; i < TBL_DEPTH; i++)
                  if (tbl_valid[i])
                     tbl_rank[i]++;
               tbl_valid[s]    = 1'b1;
               tbl_key[s]      = k;
               tbl_class[s]    = cls;
               tbl_hit_mark[s] = 1'b0;
               tbl_rank[s]     = 0;
               tbl_fill++;
               if (cls == lts_pkg::CLASS_PREFETCHED)
                  cnt_pf_inserts++;
            end
         end
         lts_pkg::OP_REMOVE_LRU, lts_pkg::OP_REMOVE_KEY: begin
            s = -1;
            if (op == lts_pkg::OP_REMOVE_KEY) begin
               r.out_key = k;
               s = find_entry(k);
            end else begin
               for (int i = 0; i < TBL_DEPTH; i++)
                  if (tbl_valid[i] && tbl_rank[i] + 1 == tbl_fill)
                     s = i;
            end
            if (s < 0) begin
               r.status = lts_pkg::STATUS_ABSENT;
            end else begin
               r.out_key     = tbl_key[s];
               r.out_class   = tbl_class[s];
               r.out_was_hit = tbl_hit_mark[s];
               rank = tbl_rank[s];
               tbl_valid[s] = 1'b0;
               for (int i = 0; i < TBL_DEPTH; i++)
                  if (tbl_valid[i] && tbl_rank[i] > rank)
                     tbl_rank[i]--;
               tbl_fill--;
            end
         end
         default: ;
      endcase
      r.occupancy          = tbl_fill[lts_pkg::OCC_W-1:0];
      r.prefetched_hits    = cnt_pf_hits;
      r.plain_hits         = cnt_plain_hits;
      r.prefetched_inserts = cnt_pf_inserts;
      return r;
   endfunction

   task automatic send_request(logic [lts_pkg::OP_W-1:0] op, logic [lts_pkg::KEY_W-1:0] k,
                               logic [lts_pkg::CLASS_W-1:0] cls);
      int            gap;
      table_rsp_type exp_rsp;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(lts_pkg::REQ_TDATA_W - lts_pkg::KEY_W - lts_pkg::CLASS_W){1'b0}},
                     cls, k};
      req_tuser  <= op;
      do
         @(posedge clock);
      while (!req_tready);
      exp_rsp = apply_table_op(op, k, cls);
      expected_table_rsp.insert(expected_table_rsp.size(), exp_rsp);
   endtask

   // The response side stalls in short random bursts, or for a long stretch when asked.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, logic [lts_pkg::COUNT_W-1:0] exp_val,
                                       logic [lts_pkg::COUNT_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      table_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_table_rsp.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_table_rsp.pop_front();
            check_field("hit", e.hit, rsp_tdata[0]);
            check_field("out_key", e.out_key, rsp_tdata[32:1]);
            check_field("out_class", e.out_class, rsp_tdata[34:33]);
            check_field("out_was_hit", e.out_was_hit, rsp_tdata[35]);
            check_field("status", e.status, rsp_tdata[37:36]);
            check_field("occupancy", e.occupancy, rsp_tdata[42:38]);
            check_field("prefetched_hits", e.prefetched_hits, rsp_tdata[74:43]);
            check_field("plain_hits", e.plain_hits, rsp_tdata[106:75]);
            check_field("prefetched_inserts", e.prefetched_inserts, rsp_tdata[138:107]);
         end
      end
   end

   // Edge keys and every class, hits on each class, and removes that find nothing.
   task automatic test_directed();
      send_request(lts_pkg::OP_REMOVE_LRU, 32'h0000_0000, lts_pkg::CLASS_PREFETCHED);
      send_request(lts_pkg::OP_REMOVE_KEY, 32'hFFFF_FFFF, lts_pkg::CLASS_PLAIN);
      send_request(lts_pkg::OP_ACCESS, 32'h0000_0000, lts_pkg::CLASS_PREFETCHED);
      send_request(lts_pkg::OP_ACCESS, 32'hFFFF_FFFF, lts_pkg::CLASS_PLAIN);
      send_request(lts_pkg::OP_ACCESS, 32'h8000_0000, lts_pkg::CLASS_RESERVED);
      send_request(lts_pkg::OP_ACCESS, 32'h0000_0001, lts_pkg::CLASS_UNKNOWN);
      send_request(lts_pkg::OP_ACCESS, 32'h0000_0000, lts_pkg::CLASS_PLAIN);
      send_request(lts_pkg::OP_ACCESS, 32'hFFFF_FFFF, lts_pkg::CLASS_PREFETCHED);
      send_request(lts_pkg::OP_ACCESS, 32'h8000_0000, lts_pkg::CLASS_PREFETCHED);
      send_request(OP_IGNORED, 32'hFFFF_FFFF, lts_pkg::CLASS_RESERVED);
      send_request(lts_pkg::OP_REMOVE_KEY, 32'h1234_5678, lts_pkg::CLASS_RESERVED);
      send_request(lts_pkg::OP_REMOVE_KEY, 32'hFFFF_FFFF, lts_pkg::CLASS_PREFETCHED);
      send_request(lts_pkg::OP_REMOVE_LRU, 32'hFFFF_FFFF, lts_pkg::CLASS_RESERVED);
      send_request(lts_pkg::OP_ACCESS, 32'hA5A5_5A5A, lts_pkg::CLASS_PREFETCHED);
      send_request(lts_pkg::OP_REMOVE_LRU, 32'h0000_0000, lts_pkg::CLASS_PREFETCHED);
      send_request(lts_pkg::OP_REMOVE_KEY, 32'h8000_0000, lts_pkg::CLASS_PLAIN);
      send_request(lts_pkg::OP_REMOVE_LRU, 32'h0000_0000, lts_pkg::CLASS_PLAIN);
      send_request(lts_pkg::OP_REMOVE_LRU, 32'h0000_0000, lts_pkg::CLASS_PLAIN);
   endtask

   // Fill to capacity, miss on the full table, hit while full, then drain past empty.
   task automatic test_full_table();
      logic [lts_pkg::KEY_W-1:0] k;
      int                        s;
      while (tbl_fill < TBL_DEPTH) begin
         do
            k = $urandom;
         while (find_entry(k) >= 0);
         send_request(lts_pkg::OP_ACCESS, k, lts_pkg::CLASS_W'($urandom_range(0, 3)));
      end
      do
         k = $urandom;
      while (find_entry(k) >= 0);
      send_request(lts_pkg::OP_ACCESS, k, lts_pkg::CLASS_PREFETCHED);
      s = $urandom_range(0, TBL_DEPTH - 1);
      send_request(lts_pkg::OP_ACCESS, tbl_key[s], lts_pkg::CLASS_PLAIN);
      while (tbl_fill > 0)
         send_request(lts_pkg::OP_REMOVE_LRU, $urandom,
                      lts_pkg::CLASS_W'($urandom_range(0, 3)));
      send_request(lts_pkg::OP_REMOVE_LRU, $urandom, lts_pkg::CLASS_PREFETCHED);
   endtask

   // The response side holds off long enough for the block to stall its request side.
   task automatic test_backpressure();
      hold_cycles = 300;
      for (int n = 0; n < 30; n++)
         send_request(lts_pkg::OP_ACCESS, key_pool[$urandom_range(0, 7)],
                      lts_pkg::CLASS_W'($urandom_range(0, 3)));
   endtask

   task automatic random_phase(int count, int access_pct, int lru_pct);
      int                          pick;
      logic [lts_pkg::KEY_W-1:0]   k;
      logic [lts_pkg::CLASS_W-1:0] cls;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         cls  = lts_pkg::CLASS_W'($urandom_range(0, 3));
         k    = ($urandom_range(0, 7) == 0) ? $urandom
                                            : key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < access_pct)
            send_request(lts_pkg::OP_ACCESS, k, cls);
         else if (pick < access_pct + lru_pct)
            send_request(lts_pkg::OP_REMOVE_LRU, k, cls);
         else if (pick < 97)
            send_request(lts_pkg::OP_REMOVE_KEY, k, cls);
         else
            send_request(OP_IGNORED, k, cls);
      end
   endtask

   task automatic test_random();
      random_phase(250, 75, 8);
      random_phase(250, 45, 30);
      random_phase(250, 60, 15);
      idle_on = 1'b0;
      random_phase(250, 62, 18);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = lts_pkg::OP_ACCESS;
      tbl_fill       = 0;
      cnt_pf_hits    = '0;
      cnt_plain_hits = '0;
      cnt_pf_inserts = '0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         tbl_valid[i]    = 1'b0;
         tbl_key[i]      = '0;
         tbl_class[i]    = '0;
         tbl_hit_mark[i] = 1'b0;
         tbl_rank[i]     = 0;
      end
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_table_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #1600000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
